### design/lzc_pkg.sv
// Shared constants and controller/datapath interface types for the LZ77 window compressor.
`default_nettype none
package lzc_pkg;

	localparam int RING_AW   = 11;
	localparam int RING_DEPTH = 1 << RING_AW;
	localparam int WIN_AW    = 10;
	localparam int LEN_W     = 7;
	localparam int FILL_W    = 5;
	localparam int GRP_DEPTH = 16;

	localparam logic [WIN_AW-1:0]  WIN_LEN   = 10'd1023;
	localparam logic [LEN_W-1:0]   MAX_MATCH = 7'd66;
	localparam logic [LEN_W-1:0]   MIN_MATCH = 7'd3;
	// Location bias: one past the start, less the lookahead length, modulo the window.
	localparam logic [WIN_AW-1:0]  LOC_BIAS  = 10'd959;
	// Adding this moves a ring address back by one window length.
	localparam logic [RING_AW-1:0] WIN_BACK  = 11'd1025;

	typedef struct packed {
		logic wr;
		logic set_ended;
		logic srch_init;
		logic rd;
		logic eval;
		logic fin;
		logic emit;
		logic emit_final;
		logic empty;
		logic push;
		logic clear;
	} lzc_cmd_t;

	typedef struct packed {
		logic la_full_next;
		logic la_zero;
		logic ended;
		logic srch_end;
		logic grp_full;
		logic grp_zero;
		logic emit_last;
		logic out_free;
	} lzc_status_t;

endpackage
`default_nettype wire

### design/lzc_ctrl.sv
// Controller state machine sequencing input beats, the window search, and output groups.
`default_nettype none
module lzc_ctrl (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	input  wire logic                 in_end,
	output logic                      in_ready,
	input  wire lzc_pkg::lzc_status_t st,
	output lzc_pkg::lzc_cmd_t         cmd
);

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_RD     = 9'b000000010,
		ST_EV     = 9'b000000100,
		ST_DECIDE = 9'b000001000,
		ST_EMIT   = 9'b000010000,
		ST_EMITF  = 9'b000100000,
		ST_EMPTY  = 9'b001000000,
		ST_PUSH   = 9'b010000000,
		ST_CLEAR  = 9'b100000000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd      = '0;
		in_ready = 1'b0;
		state_d  = state_q;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					if (!in_end) begin
						if (!st.ended) begin
							cmd.wr = 1'b1;
							if (st.la_full_next) begin
								cmd.srch_init = 1'b1;
								state_d       = ST_RD;
							end
						end
					end else begin
						cmd.set_ended = 1'b1;
						if (!st.la_zero) begin
							cmd.srch_init = 1'b1;
							state_d       = ST_RD;
						end else if (st.grp_zero) begin
							state_d = ST_EMPTY;
						end else begin
							state_d = ST_EMITF;
						end
					end
				end
			end
			ST_RD: begin
				if (st.srch_end) begin
					cmd.fin = 1'b1;
					state_d = ST_DECIDE;
				end else begin
					cmd.rd  = 1'b1;
					state_d = ST_EV;
				end
			end
			ST_EV: begin
				cmd.eval = 1'b1;
				state_d  = ST_RD;
			end
			ST_DECIDE: begin
				state_d = st.grp_full ? ST_EMIT : ST_PUSH;
			end
			ST_EMIT: begin
				if (st.out_free) begin
					cmd.emit = 1'b1;
					if (st.emit_last) begin
						state_d = ST_PUSH;
					end
				end
			end
			ST_EMITF: begin
				if (st.out_free) begin
					cmd.emit       = 1'b1;
					cmd.emit_final = 1'b1;
					if (st.emit_last) begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_EMPTY: begin
				if (st.out_free) begin
					cmd.empty = 1'b1;
					state_d   = ST_CLEAR;
				end
			end
			ST_PUSH: begin
				cmd.push = 1'b1;
				state_d  = ST_IDLE;
			end
			ST_CLEAR: begin
				cmd.clear = 1'b1;
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

### design/lzc_datapath.sv
// Datapath: history ring, window search registers, group buffer and output register.
`default_nettype none
module lzc_datapath (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic [7:0]           in_byte,
	input  wire lzc_pkg::lzc_cmd_t    cmd,
	output lzc_pkg::lzc_status_t      st,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [7:0]                out_byte,
	output logic                      group_last,
	output logic                      stream_last,
	output logic                      empty_marker
);

	localparam int AW = lzc_pkg::RING_AW;
	localparam int WW = lzc_pkg::WIN_AW;
	localparam int LW = lzc_pkg::LEN_W;
	localparam int FW = lzc_pkg::FILL_W;

	logic [7:0]    ring_q [lzc_pkg::RING_DEPTH];
	logic [7:0]    rd_win_q, rd_la_q;
	logic          win_ok_q;

	logic [AW-1:0] wi_q;
	logic          wrap_q;
	logic [LW-1:0] la_q;
	logic [WW-1:0] sp_q;
	logic [7:0]    mask_q;
	logic [3:0]    tok_q;
	logic [FW-1:0] fill_q;
	logic          ended_q;
	logic [7:0]    grp_q [lzc_pkg::GRP_DEPTH];

	logic [WW-1:0] w_q, start_q, best_off_q;
	logic [LW-1:0] len_q, best_len_q;
	logic [7:0]    first_q;
	logic [FW-1:0] e_q;

	logic          out_valid_q;
	logic [7:0]    out_byte_q;
	logic          glast_q, slast_q, empty_q;

	logic [AW-1:0] cur, win_addr, la_addr;
	logic [7:0]    win_b;
	logic          hit;
	logic          lit;
	logic [WW-1:0] loc;
	logic [7:0]    tok_b0;
	logic [LW-1:0] step_len;
	logic [LW-1:0] len_m3;
	logic [3:0]    shamt;
	logic [7:0]    emit_byte;
	logic [3:0]    grp_rd;
	logic          emit_end;
	logic          out_free;

	assign cur      = wi_q - {{(AW-LW){1'b0}}, la_q};
	assign win_addr = cur + {1'b0, w_q} + lzc_pkg::WIN_BACK;
	assign la_addr  = cur + {{(AW-LW){1'b0}}, len_q};

	// The ring reads as zeros wherever this stream has not written yet.
	assign win_b = win_ok_q ? rd_win_q : 8'd0;
	assign hit   = (win_b == rd_la_q);

	assign lit      = (best_len_q < lzc_pkg::MIN_MATCH);
	assign loc      = sp_q + best_off_q + lzc_pkg::LOC_BIAS;
	assign len_m3   = best_len_q - lzc_pkg::MIN_MATCH;
	assign tok_b0   = {len_m3[5:0], loc[9:8]};
	assign step_len = lit ? 7'd1 : best_len_q;

	assign shamt     = 4'd8 - tok_q;
	assign grp_rd    = 4'(e_q - 5'd1);
	assign emit_byte = (e_q == '0) ? (mask_q >> shamt) : grp_q[grp_rd];
	assign emit_end  = (e_q == fill_q);
	assign out_free  = !out_valid_q || out_ready;

	always_comb begin
		st.la_full_next = (la_q >= (lzc_pkg::MAX_MATCH - 7'd1));
		st.la_zero      = (la_q == '0);
		st.ended        = ended_q;
		st.srch_end     = (w_q == lzc_pkg::WIN_LEN);
		st.grp_full     = (tok_q == 4'd8);
		st.grp_zero     = (tok_q == 4'd0);
		st.emit_last    = emit_end;
		st.out_free     = out_free;
	end

	always_ff @(posedge clk) begin
		if (cmd.wr) begin
			ring_q[wi_q] <= in_byte;
		end
		rd_win_q <= ring_q[win_addr];
		rd_la_q  <= ring_q[la_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_ok_q <= 1'b0;
		end else if (cmd.rd) begin
			win_ok_q <= wrap_q || (win_addr < wi_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wi_q       <= '0;
			wrap_q     <= 1'b0;
			la_q       <= '0;
			sp_q       <= '0;
			mask_q     <= '0;
			tok_q      <= '0;
			fill_q     <= '0;
			ended_q    <= 1'b0;
			w_q        <= '0;
			len_q      <= '0;
			start_q    <= '0;
			best_len_q <= '0;
			best_off_q <= '0;
			e_q        <= '0;
		end else begin
			if (cmd.wr) begin
				wi_q <= wi_q + 11'd1;
				if (wi_q == '1) begin
					wrap_q <= 1'b1;
				end
				la_q <= la_q + 7'd1;
			end
			if (cmd.set_ended) begin
				ended_q <= 1'b1;
			end
			if (cmd.srch_init) begin
				w_q        <= '0;
				len_q      <= '0;
				best_len_q <= '0;
				best_off_q <= '0;
			end
			if (cmd.eval) begin
				if (len_q == '0) begin
					if (hit) begin
						len_q   <= 7'd1;
						start_q <= w_q;
					end
					w_q <= w_q + 10'd1;
				end else if (len_q < la_q && len_q < lzc_pkg::MAX_MATCH && hit) begin
					len_q <= len_q + 7'd1;
					w_q   <= w_q + 10'd1;
				end else begin
					// The run has ended; the next compare restarts at this byte.
					if (len_q > best_len_q) begin
						best_len_q <= len_q;
						best_off_q <= start_q;
					end
					len_q <= '0;
				end
			end
			if (cmd.fin && len_q > best_len_q) begin
				best_len_q <= len_q;
				best_off_q <= start_q;
			end
			if (cmd.emit) begin
				if (emit_end) begin
					e_q    <= '0;
					mask_q <= '0;
					tok_q  <= '0;
					fill_q <= '0;
				end else begin
					e_q <= e_q + 5'd1;
				end
			end
			if (cmd.push) begin
				mask_q <= {lit, mask_q[7:1]};
				tok_q  <= tok_q + 4'd1;
				if (fill_q < 5'd16) begin
					if (!lit && fill_q < 5'd15) begin
						fill_q <= fill_q + 5'd2;
					end else begin
						fill_q <= fill_q + 5'd1;
					end
				end
				la_q <= la_q - step_len;
				sp_q <= sp_q + {{(WW-LW){1'b0}}, step_len};
			end
			if (cmd.clear) begin
				wi_q    <= '0;
				wrap_q  <= 1'b0;
				la_q    <= '0;
				sp_q    <= '0;
				mask_q  <= '0;
				tok_q   <= '0;
				fill_q  <= '0;
				ended_q <= 1'b0;
				e_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.eval && len_q == '0) begin
			first_q <= rd_la_q;
		end
		if (cmd.push) begin
			for (int i = 0; i < lzc_pkg::GRP_DEPTH; i++) begin
				if (fill_q == FW'(i)) begin
					grp_q[i] <= lit ? first_q : tok_b0;
				end else if (!lit && fill_q + 5'd1 == FW'(i)) begin
					grp_q[i] <= loc[7:0];
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit || cmd.empty) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_byte_q <= emit_byte;
			glast_q    <= emit_end;
			slast_q    <= emit_end && cmd.emit_final;
			empty_q    <= 1'b0;
		end else if (cmd.empty) begin
			out_byte_q <= 8'd0;
			glast_q    <= 1'b0;
			slast_q    <= 1'b1;
			empty_q    <= 1'b1;
		end
	end

	assign out_valid    = out_valid_q;
	assign out_byte     = out_byte_q;
	assign group_last   = glast_q;
	assign stream_last  = slast_q;
	assign empty_marker = empty_q;

endmodule
`default_nettype wire

### design/lz77_window_compressor_core.sv
// Top level of the LZ77 window compressor: controller and datapath joined.
//
// Input channel (s_*): one beat per uncompressed byte with s_tuser low, and one
// beat with s_tuser high to mark the end of input. Each end beat decides one
// more token while lookahead remains; the end beat that finds none finishes
// the stream and returns the block to its reset state.
// Output channel (m_*): the packed stream, one byte per beat. A mask byte
// leads each group of up to eight tokens; m_tuser bit 0 flags the last byte
// of a group, m_tlast the last byte of the stream, and m_tuser bit 1 an empty
// stream marker.
// A byte that does not complete the 66-byte lookahead is only written to the
// history ring. A beat that decides a token runs the window search: each compare
// step on the history ring reads both ports and then compares, and a run that
// stops before the window end compares its stopping byte again. When the group
// is full, it goes out first, before the new token is pushed.
// The history reads as zeros before the start of each stream, tracked by the
// write count, so neither reset nor stream end needs a clearing pass.
// The output register holds a beat while m_tready is low; emission waits on
// it, and no input beat is taken until the current token is complete.
`default_nettype none
module lz77_window_compressor_core (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_tvalid,
	output logic            s_tready,
	input  wire logic [7:0] s_tdata,   // [7:0] in_byte
	input  wire logic [0:0] s_tuser,   // [0] in_end
	output logic            m_tvalid,
	input  wire logic       m_tready,
	output logic [7:0]      m_tdata,   // [7:0] out_byte
	output logic [1:0]      m_tuser,   // [0] group_last, [1] empty_marker
	output logic            m_tlast
);

	lzc_pkg::lzc_cmd_t    cmd;
	lzc_pkg::lzc_status_t st;
	logic                 glast, empty;

	lzc_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_end   (s_tuser[0]),
		.in_ready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	lzc_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_byte      (s_tdata),
		.cmd          (cmd),
		.st           (st),
		.out_valid    (m_tvalid),
		.out_ready    (m_tready),
		.out_byte     (m_tdata),
		.group_last   (glast),
		.stream_last  (m_tlast),
		.empty_marker (empty)
	);

	assign m_tuser = {empty, glast};

endmodule
`default_nettype wire

### design/lzc_checker.sv
// Port-level checks for the LZ77 window compressor, bound to the top level.
`default_nettype none
module lzc_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_tvalid,
	input wire logic       s_tready,
	input wire logic [0:0] s_tuser,
	input wire logic       m_tvalid,
	input wire logic       m_tready,
	input wire logic [7:0] m_tdata,
	input wire logic [1:0] m_tuser,
	input wire logic       m_tlast
);

	// A stalled output beat holds.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("output beat changed while stalled");

	// The empty marker is the whole stream: last beat, zero data, no group end.
	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[1] |-> m_tlast && m_tdata == 8'd0 && !m_tuser[0])
		else $error("malformed empty stream marker");

	// The final beat of a non-empty stream also closes its group.
	a_last_group: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast && !m_tuser[1] |-> m_tuser[0])
		else $error("stream ended inside a group");

	// A data beat never brings up a fresh empty marker in the following cycle.
	a_in_after_out: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && !s_tuser[0] |=> !(m_tvalid && m_tuser[1] && !$past(m_tvalid)))
		else $error("empty marker raised by a data beat");

endmodule

bind lz77_window_compressor_core lzc_checker u_lzc_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.s_tuser  (s_tuser),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser),
	.m_tlast  (m_tlast)
);
`default_nettype wire
